### hw/rtl/color_blob_centroid_macros.svh
// Assertion macros shared by the color blob centroid RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef COLOR_BLOB_CENTROID_MACROS_SVH
`define COLOR_BLOB_CENTROID_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define CBC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define CBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");
`else
`define CBC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define CBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

### hw/rtl/cbc_pkg.sv
// Shared constants and types of the color blob centroid block.
// No dependencies; used by every module of the block.
`default_nettype none

package cbc_pkg;

	// Saturation limit of the qualifying point count.
	localparam int unsigned MAX_POINTS = 4194304;

	// Field widths.
	localparam int COORD_W    = 16;
	localparam int COLOR_W    = 8;
	localparam int MARGIN_W   = 8;
	localparam int SEL_W      = 2;
	localparam int MINP_W     = 23;
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int SUM_W      = COORD_W + $clog2(MAX_POINTS);
	localparam int CMP_W      = (CNT_W > MINP_W) ? CNT_W : MINP_W;

	// Target channel codes of color_select; the last code matches no point.
	localparam logic [SEL_W-1:0] COLOR_RED   = 2'd0;
	localparam logic [SEL_W-1:0] COLOR_GREEN = 2'd1;
	localparam logic [SEL_W-1:0] COLOR_BLUE  = 2'd2;
	localparam logic [SEL_W-1:0] COLOR_NONE  = 2'd3;

	// Configuration port.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	// Job queue between front and back (depth is a power of two).
	localparam int JOB_DEPTH  = 2;
	localparam int JQ_PTR_W   = $clog2(JOB_DEPTH);
	localparam int JQ_LVL_W   = $clog2(JOB_DEPTH + 1);

	// Divider.
	localparam int NUM_AXES   = 3;
	localparam int DIV_STEPS  = COORD_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COLOR_SELECT = 3'd0,
		CFG_COLOR_MARGIN = 3'd1,
		CFG_MIN_POINTS   = 3'd2,
		CFG_Z_MIN_MM     = 3'd3,
		CFG_Z_MAX_MM     = 3'd4
	} cfg_idx_t;

	typedef logic signed [SUM_W-1:0] sum_t;

	// One finished cloud handed from the front to the back.
	typedef struct packed {
		logic                     found;
		logic [CNT_W-1:0]         count;
		sum_t [NUM_AXES-1:0]      sum;
	} job_t;

	// Job queue status seen by both sides.
	typedef struct packed {
		logic                empty;
		logic [JQ_LVL_W-1:0] level;
	} jq_stat_t;

endpackage

`default_nettype wire

### hw/rtl/color_blob_centroid.sv
// Top level of the color blob centroid block: front, job queue and back.
// Depends on cbc_pkg, cbc_front, cbc_job_fifo and cbc_back.
`default_nettype none

// A point is taken every clock while full is low; each point passes one
// classification register and is added to the running sums the next cycle.
// A point marked last_point closes its cloud: the sums and count move into a
// two-deep job queue and the divider in the back works the three means out
// in parallel, one quotient bit per cycle. A cloud that found an object is
// divided before its result beat is loaded, and one that did not goes straight
// to its result beat. The back takes a new cloud from the queue only once the
// last one's result beat is loaded into the output register. full rises
// when the queue entries, counting a cloud end still in the classification
// register, are all taken by clouds waiting for the divider; a result beat
// waits on the output until popped while the next cloud keeps accumulating.
// Configuration writes are accepted on every cycle and must only be made
// while the block is idle. There is no clearing pass after reset.
module color_blob_centroid (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [cbc_pkg::COLOR_W-1:0]        red,
	input  wire logic [cbc_pkg::COLOR_W-1:0]        green,
	input  wire logic [cbc_pkg::COLOR_W-1:0]        blue,
	input  wire logic signed [cbc_pkg::COORD_W-1:0] pos_x,
	input  wire logic signed [cbc_pkg::COORD_W-1:0] pos_y,
	input  wire logic signed [cbc_pkg::COORD_W-1:0] pos_z,
	input  wire logic                               has_depth,
	input  wire logic                               last_point,
	output logic                                    empty,
	input  wire logic                               pop,
	output logic                                    found,
	output logic [cbc_pkg::CNT_W-1:0]               point_count,
	output logic signed [cbc_pkg::COORD_W-1:0]      avg_x,
	output logic signed [cbc_pkg::COORD_W-1:0]      avg_y,
	output logic signed [cbc_pkg::COORD_W-1:0]      avg_z,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [cbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	cbc_pkg::jq_stat_t jq_stat;
	cbc_pkg::job_t     jq_in;
	cbc_pkg::job_t     jq_out;
	logic              jq_push;
	logic              jq_pop;

	// Classification and accumulation.
	cbc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.pos_x      (pos_x),
		.pos_y      (pos_y),
		.pos_z      (pos_z),
		.has_depth  (has_depth),
		.last_point (last_point),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.jq_stat    (jq_stat),
		.jq_push    (jq_push),
		.jq_job     (jq_in)
	);

	// Finished clouds waiting for the divider.
	cbc_job_fifo u_job_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (jq_push),
		.job_in  (jq_in),
		.pop     (jq_pop),
		.job_out (jq_out),
		.stat    (jq_stat)
	);

	// Division and result beat.
	cbc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.jq_stat     (jq_stat),
		.jq_job      (jq_out),
		.jq_pop      (jq_pop),
		.empty       (empty),
		.pop         (pop),
		.found       (found),
		.point_count (point_count),
		.avg_x       (avg_x),
		.avg_y       (avg_y),
		.avg_z       (avg_z)
	);

endmodule

`default_nettype wire

### hw/rtl/cbc_front.sv
// Front part: configuration registers, point classification and accumulation.
// Depends on cbc_pkg; pushes one job per cloud into cbc_job_fifo.
`default_nettype none

module cbc_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               push,
	output logic                                    full,
	input  wire logic [cbc_pkg::COLOR_W-1:0]        red,
	input  wire logic [cbc_pkg::COLOR_W-1:0]        green,
	input  wire logic [cbc_pkg::COLOR_W-1:0]        blue,
	input  wire logic signed [cbc_pkg::COORD_W-1:0] pos_x,
	input  wire logic signed [cbc_pkg::COORD_W-1:0] pos_y,
	input  wire logic signed [cbc_pkg::COORD_W-1:0] pos_z,
	input  wire logic                               has_depth,
	input  wire logic                               last_point,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [cbc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [cbc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire cbc_pkg::jq_stat_t                  jq_stat,
	output logic                                    jq_push,
	output cbc_pkg::job_t                           jq_job
);

	logic [cbc_pkg::SEL_W-1:0]          color_select_q;
	logic [cbc_pkg::MARGIN_W-1:0]       color_margin_q;
	logic [cbc_pkg::MINP_W-1:0]         min_points_q;
	logic signed [cbc_pkg::COORD_W-1:0] z_min_q;
	logic signed [cbc_pkg::COORD_W-1:0] z_max_q;

	logic [cbc_pkg::COLOR_W-1:0]        tgt;
	logic [cbc_pkg::COLOR_W-1:0]        oth_a;
	logic [cbc_pkg::COLOR_W-1:0]        oth_b;
	logic                               sel_ok;
	logic                               col_hit;
	logic                               z_ok;
	logic                               qual;
	logic                               accept;

	logic                               valid_s1;
	logic                               qual_s1;
	logic                               last_s1;
	logic signed [cbc_pkg::COORD_W-1:0] x_s1;
	logic signed [cbc_pkg::COORD_W-1:0] y_s1;
	logic signed [cbc_pkg::COORD_W-1:0] z_s1;

	cbc_pkg::sum_t                      sum_x_q;
	cbc_pkg::sum_t                      sum_y_q;
	cbc_pkg::sum_t                      sum_z_q;
	logic [cbc_pkg::CNT_W-1:0]          cnt_q;
	cbc_pkg::sum_t                      sum_x_nxt;
	cbc_pkg::sum_t                      sum_y_nxt;
	cbc_pkg::sum_t                      sum_z_nxt;
	logic [cbc_pkg::CNT_W-1:0]          cnt_nxt;
	logic                               inc;
	logic                               pend;
	logic [cbc_pkg::JQ_LVL_W:0]         lvl_ext;
	logic [cbc_pkg::MINP_W-1:0]         need;

	// Register writes are always taken.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_select_q <= cbc_pkg::COLOR_RED;
			color_margin_q <= 8'd50;
			min_points_q   <= 23'd10;
			z_min_q        <= 16'sd200;
			z_max_q        <= 16'sd1500;
		end else if (cfg_valid) begin
			unique case (cbc_pkg::cfg_idx_t'(cfg_index))
				cbc_pkg::CFG_COLOR_SELECT: begin
					color_select_q <= cfg_data[cbc_pkg::SEL_W-1:0];
				end
				cbc_pkg::CFG_COLOR_MARGIN: begin
					color_margin_q <= cfg_data[cbc_pkg::MARGIN_W-1:0];
				end
				cbc_pkg::CFG_MIN_POINTS: begin
					min_points_q <= cfg_data[cbc_pkg::MINP_W-1:0];
				end
				cbc_pkg::CFG_Z_MIN_MM: begin
					z_min_q <= cfg_data[cbc_pkg::COORD_W-1:0];
				end
				cbc_pkg::CFG_Z_MAX_MM: begin
					z_max_q <= cfg_data[cbc_pkg::COORD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Pick the target channel and the two it must beat.
	always_comb begin
		tgt    = red;
		oth_a  = green;
		oth_b  = blue;
		sel_ok = 1'b1;
		unique case (color_select_q)
			cbc_pkg::COLOR_RED: begin
				tgt   = red;
				oth_a = green;
				oth_b = blue;
			end
			cbc_pkg::COLOR_GREEN: begin
				tgt   = green;
				oth_a = red;
				oth_b = blue;
			end
			cbc_pkg::COLOR_BLUE: begin
				tgt   = blue;
				oth_a = red;
				oth_b = green;
			end
			default: begin
				sel_ok = 1'b0;
			end
		endcase
	end

	// A point qualifies on depth, z window and strict color excess.
	assign col_hit = sel_ok
		&& ({1'b0, tgt} > ({1'b0, oth_a} + {1'b0, color_margin_q}))
		&& ({1'b0, tgt} > ({1'b0, oth_b} + {1'b0, color_margin_q}));
	assign z_ok   = (pos_z >= z_min_q) && (pos_z <= z_max_q);
	assign qual   = has_depth && z_ok && col_hit;

	// Hold off input while the queue has no room left for a cloud end.
	assign pend    = valid_s1 && last_s1;
	assign lvl_ext = {1'b0, jq_stat.level} + {{cbc_pkg::JQ_LVL_W{1'b0}}, pend};
	assign full    = lvl_ext >= (cbc_pkg::JQ_LVL_W + 1)'(cbc_pkg::JOB_DEPTH);
	assign accept  = push && !full;

	// Classification stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			qual_s1 <= qual;
			last_s1 <= last_point;
			x_s1    <= pos_x;
			y_s1    <= pos_y;
			z_s1    <= pos_z;
		end
	end

	// Accumulation; the count saturates at its limit.
	assign inc       = valid_s1 && qual_s1
		&& (cnt_q < cbc_pkg::CNT_W'(cbc_pkg::MAX_POINTS));
	assign cnt_nxt   = cnt_q + cbc_pkg::CNT_W'(inc);
	assign sum_x_nxt = inc ? sum_x_q + cbc_pkg::sum_t'(x_s1) : sum_x_q;
	assign sum_y_nxt = inc ? sum_y_q + cbc_pkg::sum_t'(y_s1) : sum_y_q;
	assign sum_z_nxt = inc ? sum_z_q + cbc_pkg::sum_t'(z_s1) : sum_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_x_q <= '0;
			sum_y_q <= '0;
			sum_z_q <= '0;
			cnt_q   <= '0;
		end else if (valid_s1) begin
			if (last_s1) begin
				sum_x_q <= '0;
				sum_y_q <= '0;
				sum_z_q <= '0;
				cnt_q   <= '0;
			end else begin
				sum_x_q <= sum_x_nxt;
				sum_y_q <= sum_y_nxt;
				sum_z_q <= sum_z_nxt;
				cnt_q   <= cnt_nxt;
			end
		end
	end

	// A zero minimum acts as one, so found always has a nonzero count.
	assign need = (min_points_q == '0) ? cbc_pkg::MINP_W'(1) : min_points_q;

	// Hand the finished cloud to the back.
	assign jq_push      = pend;
	assign jq_job.found = cbc_pkg::CMP_W'(cnt_nxt) >= cbc_pkg::CMP_W'(need);
	assign jq_job.count = cnt_nxt;
	assign jq_job.sum   = {sum_z_nxt, sum_y_nxt, sum_x_nxt};

endmodule

`default_nettype wire

### hw/rtl/cbc_job_fifo.sv
// Short job queue that decouples the accumulating front from the divider back.
// Depends on cbc_pkg and the assertion macros header.
`default_nettype none
`include "color_blob_centroid_macros.svh"

module cbc_job_fifo (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cbc_pkg::job_t job_in,
	input  wire logic          pop,
	output cbc_pkg::job_t      job_out,
	output cbc_pkg::jq_stat_t  stat
);

	cbc_pkg::job_t                mem_q [cbc_pkg::JOB_DEPTH];
	logic [cbc_pkg::JQ_PTR_W-1:0] wr_ptr_q;
	logic [cbc_pkg::JQ_PTR_W-1:0] rd_ptr_q;
	logic [cbc_pkg::JQ_LVL_W-1:0] level_q;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= job_in;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	assign job_out    = mem_q[rd_ptr_q];
	assign stat.empty = (level_q == '0);
	assign stat.level = level_q;

	// The front reserves room before it takes a cloud end, the back pops only data.
	`CBC_ASSERT_IMPLIES(a_jq_no_overflow, clk, arst_n, push, level_q < cbc_pkg::JQ_LVL_W'(cbc_pkg::JOB_DEPTH))
	`CBC_ASSERT_IMPLIES(a_jq_no_underflow, clk, arst_n, pop, level_q != '0)

endmodule

`default_nettype wire

### hw/rtl/cbc_back.sv
// Back part: divides the cloud sums by the count and holds the result beat.
// Depends on cbc_pkg and the assertion macros header; fed by cbc_job_fifo.
`default_nettype none
`include "color_blob_centroid_macros.svh"

module cbc_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire cbc_pkg::jq_stat_t           jq_stat,
	input  wire cbc_pkg::job_t               jq_job,
	output logic                             jq_pop,
	output logic                             empty,
	input  wire logic                        pop,
	output logic                             found,
	output logic [cbc_pkg::CNT_W-1:0]        point_count,
	output logic signed [cbc_pkg::COORD_W-1:0] avg_x,
	output logic signed [cbc_pkg::COORD_W-1:0] avg_y,
	output logic signed [cbc_pkg::COORD_W-1:0] avg_z
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                             state_q;
	logic [cbc_pkg::STEP_W-1:0]         step_q;
	logic [cbc_pkg::SUM_W-1:0]          dsh_q;
	logic [cbc_pkg::SUM_W-1:0]          rem_q [cbc_pkg::NUM_AXES];
	logic [cbc_pkg::COORD_W-1:0]        quo_q [cbc_pkg::NUM_AXES];
	logic                               neg_q [cbc_pkg::NUM_AXES];
	logic                               job_found_q;
	logic [cbc_pkg::CNT_W-1:0]          job_count_q;

	logic                               res_valid_q;
	logic                               found_q;
	logic [cbc_pkg::CNT_W-1:0]          count_q;
	logic signed [cbc_pkg::COORD_W-1:0] avg_q [cbc_pkg::NUM_AXES];

	logic [cbc_pkg::SUM_W:0]            diff [cbc_pkg::NUM_AXES];
	logic [cbc_pkg::SUM_W-1:0]          mag [cbc_pkg::NUM_AXES];
	logic                               out_pop;
	logic                               can_load;

	assign jq_pop   = (state_q == ST_IDLE) && !jq_stat.empty;
	assign out_pop  = pop && res_valid_q;
	assign can_load = !res_valid_q || out_pop;

	// Magnitudes of the incoming sums and one restoring step per lane.
	always_comb begin
		for (int i = 0; i < cbc_pkg::NUM_AXES; i++) begin
			mag[i]  = jq_job.sum[i][cbc_pkg::SUM_W-1] ? (~jq_job.sum[i] + 1'b1)
				: jq_job.sum[i];
			diff[i] = {1'b0, rem_q[i]} - {1'b0, dsh_q};
		end
	end

	// Sequencer, shared divider and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			dsh_q       <= '0;
			job_found_q <= 1'b0;
			job_count_q <= '0;
			res_valid_q <= 1'b0;
			found_q     <= 1'b0;
			count_q     <= '0;
			for (int i = 0; i < cbc_pkg::NUM_AXES; i++) begin
				rem_q[i] <= '0;
				quo_q[i] <= '0;
				neg_q[i] <= 1'b0;
				avg_q[i] <= '0;
			end
		end else begin
			// A new result beat takes priority over clearing the one just popped.
			if ((state_q == ST_DONE) && can_load) begin
				res_valid_q <= 1'b1;
			end else if (out_pop) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (jq_pop) begin
						job_found_q <= jq_job.found;
						job_count_q <= jq_job.count;
						step_q      <= '0;
						dsh_q       <= cbc_pkg::SUM_W'(jq_job.count) << (cbc_pkg::COORD_W - 1);
						for (int i = 0; i < cbc_pkg::NUM_AXES; i++) begin
							rem_q[i] <= mag[i];
							quo_q[i] <= '0;
							neg_q[i] <= jq_job.sum[i][cbc_pkg::SUM_W-1];
						end
						state_q <= jq_job.found ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					for (int i = 0; i < cbc_pkg::NUM_AXES; i++) begin
						if (!diff[i][cbc_pkg::SUM_W]) begin
							rem_q[i] <= diff[i][cbc_pkg::SUM_W-1:0];
							quo_q[i] <= {quo_q[i][cbc_pkg::COORD_W-2:0], 1'b1};
						end else begin
							quo_q[i] <= {quo_q[i][cbc_pkg::COORD_W-2:0], 1'b0};
						end
					end
					dsh_q  <= dsh_q >> 1;
					step_q <= step_q + 1'b1;
					if (step_q == cbc_pkg::STEP_W'(cbc_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (can_load) begin
						found_q     <= job_found_q;
						count_q     <= job_count_q;
						for (int i = 0; i < cbc_pkg::NUM_AXES; i++) begin
							if (!job_found_q) begin
								avg_q[i] <= '0;
							end else if (neg_q[i]) begin
								avg_q[i] <= ~quo_q[i] + 1'b1;
							end else begin
								avg_q[i] <= quo_q[i];
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty       = !res_valid_q;
	assign found       = found_q;
	assign point_count = count_q;
	assign avg_x       = avg_q[0];
	assign avg_y       = avg_q[1];
	assign avg_z       = avg_q[2];

	// A result without an object reports zero means; one with an object has points.
	`CBC_ASSERT_IMPLIES(a_nf_zero, clk, arst_n, res_valid_q && !found_q, avg_q[0] == '0 && avg_q[1] == '0 && avg_q[2] == '0)
	`CBC_ASSERT_IMPLIES(a_found_cnt, clk, arst_n, res_valid_q && found_q, count_q != '0)
	// Taking a job always leaves the idle state.
	`CBC_ASSERT_NEXT(a_job_start, clk, arst_n, jq_pop, state_q != ST_IDLE)

endmodule

`default_nettype wire
